[src/asre_pkg.sv]
package asre_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SAMPLE_W-1:0] delta_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DELTA_THRESHOLD = 2'd0,
    REG_UPPER_LIMIT     = 2'd1,
    REG_LOWER_LIMIT     = 2'd2
  } cfg_index_t;

  localparam delta_t  DELTA_THRESHOLD_RESET = '0;
  localparam sample_t UPPER_LIMIT_RESET     = 16'sh7FFF;
  localparam sample_t LOWER_LIMIT_RESET     = 16'sh8000;

endpackage

[src/asre_avg_div.sv]
// Signed block sum divided by a constant, truncated toward zero.
// Magnitude times a rounded-up reciprocal, exact for every SUM_W-bit magnitude.
module asre_avg_div import asre_pkg::*; #(
  parameter int DIVISOR = 10,
  parameter int SUM_W   = 20
) (
  input  logic signed [SUM_W-1:0] sum_i,
  output sample_t                 avg_o
);

  localparam int SHIFT  = SUM_W + $clog2(DIVISOR);
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP =
    MUL_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic               neg;
  logic [SUM_W-1:0]   mag;
  logic [PROD_W-1:0]  prod;
  logic [SAMPLE_W-1:0] qmag;

  always_comb begin
    neg  = sum_i[SUM_W-1];
    mag  = neg ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    prod = PROD_W'(mag) * PROD_W'(RECIP);
    qmag = prod[SHIFT +: SAMPLE_W];
    avg_o = neg ? sample_t'(-qmag) : sample_t'(qmag);
  end

endmodule

[src/averaged_sensor_range_event_unit.sv]
// Channel | Dir | Handshake           | Word
// in      | in  | in_valid/in_ready   | in_sample
// out     | out | out_valid/out_ready | out_reported_value, out_range_event
// cfg     | in  | cfg_we              | cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_ready holds; an accepted word passes
// the input register, then the result register, before result valid. Input register,
// then the update logic (sum add, constant-divide multiply, compare), registered
// into the result register together with the state. rst_n is synchronous: clears
// both stage valid bits, state and config registers. A stalled result holds only
// the update stage; the input register still takes one more word if it is empty.
module averaged_sensor_range_event_unit import asre_pkg::*; #(
  parameter int AVERAGE_COUNT = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sample_t                in_sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sample_t                out_reported_value,
  output logic                   out_range_event,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CNT_W = $clog2(AVERAGE_COUNT);
  localparam int SUM_W = SAMPLE_W + $clog2(AVERAGE_COUNT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AVERAGE_COUNT - 1);

  // config
  delta_t  delta_thr_r;
  sample_t upper_r;
  sample_t lower_r;

  // pipeline
  logic    s1_valid_r;
  sample_t s1_sample_r;
  logic    out_valid_r;
  sample_t out_value_r, out_value_nxt;
  logic    out_event_r, out_event_nxt;

  // state
  logic                    first_r, first_nxt;
  sample_t                 held_r, held_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    s2_load;
  logic                    exec;
  logic signed [SUM_W-1:0] sum_add;
  sample_t                 avg;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]       diff_mag;
  delta_t                  delta;
  logic                    hit;

  assign s2_load  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_load;
  assign exec     = s1_valid_r && s2_load;

  assign out_valid          = out_valid_r;
  assign out_reported_value = out_value_r;
  assign out_range_event    = out_event_r;

  assign sum_add = sum_r + SUM_W'(s1_sample_r);

  asre_avg_div #(
    .DIVISOR (AVERAGE_COUNT),
    .SUM_W   (SUM_W)
  ) u_avg_div (
    .sum_i (sum_add),
    .avg_o (avg)
  );

  always_comb begin
    diff     = $signed({s1_sample_r[SAMPLE_W-1], s1_sample_r})
             - $signed({held_r[SAMPLE_W-1], held_r});
    diff_mag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
    delta    = diff_mag[SAMPLE_W-1:0];
    hit      = (delta >= delta_thr_r) &&
               ((s1_sample_r >= upper_r) || (s1_sample_r <= lower_r));
  end

  always_comb begin
    first_nxt     = first_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    out_event_nxt = 1'b0;
    if (first_r) begin
      first_nxt     = 1'b0;
      held_nxt      = s1_sample_r;
      out_event_nxt = 1'b1;
    end else begin
      if (cnt_r == CNT_LAST) begin
        held_nxt = avg;
        sum_nxt  = '0;
        cnt_nxt  = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_r + 1'b1;
      end
      // event overrides a block average formed on the same word
      if (hit) begin
        held_nxt      = s1_sample_r;
        out_event_nxt = 1'b1;
      end
    end
    out_value_nxt = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_thr_r <= DELTA_THRESHOLD_RESET;
      upper_r     <= UPPER_LIMIT_RESET;
      lower_r     <= LOWER_LIMIT_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      held_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index_t'(cfg_index))
          REG_DELTA_THRESHOLD: delta_thr_r <= delta_t'(cfg_wdata);
          REG_UPPER_LIMIT:     upper_r     <= sample_t'(cfg_wdata);
          REG_LOWER_LIMIT:     lower_r     <= sample_t'(cfg_wdata);
          default: ;
        endcase
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
      if (exec) begin
        first_r <= first_nxt;
        held_r  <= held_nxt;
        sum_r   <= sum_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
    end
    if (exec) begin
      out_value_r <= out_value_nxt;
      out_event_r <= out_event_nxt;
    end
  end

endmodule

[src/asre_checker.sv]
module asre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_reported_value,
  input logic        out_range_event
);

  logic seen_r, seen_nxt;

  assign seen_nxt = seen_r || (out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_reported_value) && $stable(out_range_event))
    else $error("stalled result word changed or dropped");

  // an empty pipe passes an accepted word through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input word two cycles earlier");

  a_first_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_r |-> out_range_event)
    else $error("first result after reset lacks the event flag");

endmodule

bind averaged_sensor_range_event_unit asre_checker u_asre_checker (.*);

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import asre_pkg::*;

  localparam int AVG_N = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int N_PHASES = 8;
  localparam int LONG_HOLD = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    sample_t value;
    logic    flag;
  } report_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  sample_t                in_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  sample_t                out_reported_value;
  logic                   out_range_event;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  averaged_sensor_range_event_unit #(.AVERAGE_COUNT(AVG_N)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_reported_value (out_reported_value),
    .out_range_event    (out_range_event),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // sensor state as the block should hold it
  bit awaiting_first = 1'b1;
  int held_m = 0;
  int acc_sum = 0;
  int acc_cnt = 0;
  int thr_m = 0;
  int upper_m = 32767;
  int lower_m = -32768;

  sample_t samples_to_send[$];
  report_t pending_reports[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_events = 0;
  int n_averages = 0;
  int n_settings = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet = 0;
  logic in_taken = 1'b0;

  int directed_samples[] = '{
    -32768, 32767, -32768, 0, 1, -1, 100, 200, 300, 400, 500,
    21845, -21846, 7, 8, 9, 10, 11, 12, 13, 32767
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic report_t next_report(sample_t s_in);
    int s;
    int diff;
    report_t r;
    s = s_in;
    r.flag = 1'b0;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      held_m = s;
      r.flag = 1'b1;
    end else begin
      // difference is taken against the value held before this sample
      diff = s - held_m;
      if (diff < 0) diff = -diff;
      acc_sum += s;
      acc_cnt++;
      if (acc_cnt >= AVG_N) begin
        held_m = acc_sum / AVG_N;
        acc_sum = 0;
        acc_cnt = 0;
        n_averages++;
      end
      if (diff >= thr_m && (s >= upper_m || s <= lower_m)) begin
        held_m = s;
        r.flag = 1'b1;
      end
    end
    r.value = sample_t'(held_m);
    if (r.flag) n_events++;
    return r;
  endfunction

  function automatic sample_t pick_sample();
    int r;
    int v;
    r = $urandom_range(0, 9);
    case (r)
      0: v = 32767;
      1: v = -32768;
      2, 3: v = upper_m + int'($urandom_range(0, 40)) - 20;
      4, 5: v = lower_m + int'($urandom_range(0, 40)) - 20;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return sample_t'(v);
  endfunction

  task automatic report_mismatch(string field, int exp_v, int got_v);
    $display("tb: mismatch in %s at report %0d: expected %0d, got %0d",
             field, n_checked, exp_v, got_v);
    n_errors++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_DELTA_THRESHOLD: thr_m = data;
      REG_UPPER_LIMIT:     upper_m = $signed(data);
      REG_LOWER_LIMIT:     lower_m = $signed(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_limits(int thr, int up, int lo);
    write_reg(REG_DELTA_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_UPPER_LIMIT, CFG_DATA_W'(up));
    write_reg(REG_LOWER_LIMIT, CFG_DATA_W'(lo));
    n_settings++;
  endtask

  task automatic queue_sample(sample_t s);
    samples_to_send.push_back(s);
    n_queued++;
  endtask

  // every queued word accepted and every report back
  task automatic wait_idle();
    do @(negedge clk);
    while (n_accepted != n_queued || pending_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (samples_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_sample <= samples_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor: results first, then the word accepted on this edge
  always @(posedge clk) begin
    report_t exp_r;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("report with nothing pending", 0, out_reported_value);
        end else begin
          exp_r = pending_reports.pop_front();
          if (out_reported_value !== exp_r.value)
            report_mismatch("reported_value", exp_r.value, out_reported_value);
          if (out_range_event !== exp_r.flag)
            report_mismatch("range_event", exp_r.flag, out_range_event);
        end
        n_checked++;
      end
      if (in_valid && in_ready) begin
        pending_reports.push_back(next_report(in_sample));
        n_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: no handshake for %0d cycles, giving up", quiet);
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // index with no register behind it must leave everything alone
    write_reg(REG_UNUSED, 16'h1234);

    // reset limits: first sample, extremes, one averaging point, then an
    // averaging point that coincides with a range event
    foreach (directed_samples[i]) queue_sample(sample_t'(directed_samples[i]));
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: set_limits(0, 32767, -32768);
        1: set_limits(65535, -32768, 32767);   // crossed limits, widest delta
        2: set_limits(100, 1000, -1000);
        3: set_limits(0, -32768, -32768);      // every word over the top
        4: set_limits($urandom_range(0, 2000), int'($urandom_range(0, 32767)),
                      -int'($urandom_range(0, 32768)));
        5: set_limits(30000, 20000, -20000);
        6: set_limits($urandom_range(0, 65535), int'($urandom_range(0, 65535)),
                      int'($urandom_range(0, 65535)));
        default: set_limits(5, 32767, -32768);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(pick_sample());
      // back up the output while the sender keeps offering words
      if (p == 0 || p == 5) hold_reqs++;
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (pending_reports.size() != 0)
      report_mismatch("reports never returned", 0, pending_reports.size());
    $display("summary: %0d samples in, %0d reports checked, %0d range events, %0d averages",
             n_accepted, n_checked, n_events, n_averages);
    $display("summary: %0d limit settings incl. crossed and extreme limits, %0d mismatches",
             n_settings, n_errors);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
